FILE: rtl/ctpk_pkg.sv
// Shared types, constants and lookup functions for the protein k-mer encoder.
package ctpk_pkg;

    localparam int KMER_LEN_DEF       = 8;
    localparam int POSITION_WIDTH_DEF = 28;
    localparam int CODE_W             = 35;
    localparam int RES_W              = 5;
    localparam int BASE_W             = 3;
    localparam int SYM_W              = 8;
    localparam int CFG_IDX_W          = 1;
    localparam int CFG_DATA_W         = 2;

    localparam logic [RES_W-1:0]  NO_RESIDUE = 5'd20;
    localparam logic [BASE_W-1:0] BASE_BAD   = 3'd4;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FRAME_OFFSET  = 1'b0,
        REG_PROTEIN_INPUT = 1'b1
    } t_reg_idx;

    // Residue index for each codon, first base most significant; 20 marks a stop codon.
    localparam logic [RES_W-1:0] CODON_RES [64] = '{
        5'd8,  5'd11, 5'd8,  5'd11, 5'd16, 5'd16, 5'd16, 5'd16,
        5'd14, 5'd15, 5'd14, 5'd15, 5'd7,  5'd7,  5'd10, 5'd7,
        5'd13, 5'd6,  5'd13, 5'd6,  5'd12, 5'd12, 5'd12, 5'd12,
        5'd14, 5'd14, 5'd14, 5'd14, 5'd9,  5'd9,  5'd9,  5'd9,
        5'd3,  5'd2,  5'd3,  5'd2,  5'd0,  5'd0,  5'd0,  5'd0,
        5'd5,  5'd5,  5'd5,  5'd5,  5'd17, 5'd17, 5'd17, 5'd17,
        5'd20, 5'd19, 5'd20, 5'd19, 5'd15, 5'd15, 5'd15, 5'd15,
        5'd20, 5'd1,  5'd18, 5'd1,  5'd9,  5'd4,  5'd9,  5'd4
    };

    // Stage 1 beat handed from the front end to the cell row.
    typedef struct packed {
        logic             valid;
        logic             start;
        logic             has_res;
        logic [RES_W-1:0] res;
    } t_s1;

    // Contents of one window cell.
    typedef struct packed {
        logic             valid;
        logic [RES_W-1:0] res;
    } t_cell_data;

    // Control for the cells of the row.
    typedef struct packed {
        logic shift;
        logic flush;
    } t_cell_ctl;

    function automatic logic [63:0] pow20(input int n);
        logic [63:0] v;
        v = 64'd1;
        for (int i = 0; i < n; i++) begin
            v = v * 64'd20;
        end
        return v;
    endfunction

    function automatic logic [BASE_W-1:0] base_code(input logic [SYM_W-1:0] ch);
        logic [BASE_W-1:0] b;
        case (ch)
            "A", "a":           b = 3'd0;
            "C", "c":           b = 3'd1;
            "G", "g":           b = 3'd2;
            "T", "t", "U", "u": b = 3'd3;
            default:            b = BASE_BAD;
        endcase
        return b;
    endfunction

    function automatic logic [RES_W-1:0] letter_residue(input logic [SYM_W-1:0] ch);
        logic [RES_W-1:0] r;
        case (ch)
            "A":     r = 5'd0;
            "C":     r = 5'd1;
            "D":     r = 5'd2;
            "E":     r = 5'd3;
            "F":     r = 5'd4;
            "G":     r = 5'd5;
            "H":     r = 5'd6;
            "I":     r = 5'd7;
            "K":     r = 5'd8;
            "L":     r = 5'd9;
            "M":     r = 5'd10;
            "N":     r = 5'd11;
            "P":     r = 5'd12;
            "Q":     r = 5'd13;
            "R":     r = 5'd14;
            "S":     r = 5'd15;
            "T":     r = 5'd16;
            "V":     r = 5'd17;
            "W":     r = 5'd18;
            "Y":     r = 5'd19;
            default: r = NO_RESIDUE;
        endcase
        return r;
    endfunction

endpackage

FILE: rtl/ctpk_ifs.sv
// Valid/ready channel interfaces for symbols, k-mer results and register writes.
interface ctpk_in_if
    import ctpk_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [SYM_W-1:0] symbol;
    logic             seq_start;

    modport source (output valid, output symbol, output seq_start, input ready);
    modport sink   (input valid, input symbol, input seq_start, output ready);
endinterface

interface ctpk_out_if
    import ctpk_pkg::*;
#(
    parameter int POSITION_WIDTH = POSITION_WIDTH_DEF
) ();
    logic                      valid;
    logic                      ready;
    logic [CODE_W-1:0]         kmer_code;
    logic [POSITION_WIDTH-1:0] kmer_start;

    modport source (output valid, output kmer_code, output kmer_start, input ready);
    modport sink   (input valid, input kmer_code, input kmer_start, output ready);
endinterface

interface ctpk_cfg_if
    import ctpk_pkg::*;
();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: rtl/codon_translate_protein_kmer_stream_top.sv
// Top level of the rolling base-20 protein k-mer encoder.
// The symbol beat that completes a window passes the stage 1 register; its result is then held in the output register.
// Throughput: one symbol beat per cycle; the whole pipeline stalls only while a
// result sits in the output register and the sink holds ready low.
// Reset (synchronous, active low) clears the registers, the codon state, the cell row,
// the rolling code and the position, which acts as the start of a new sequence.
module codon_translate_protein_kmer_stream_top
    import ctpk_pkg::*;
#(
    parameter int KMER_LEN       = KMER_LEN_DEF,
    parameter int POSITION_WIDTH = POSITION_WIDTH_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    ctpk_in_if.sink   i_in,
    ctpk_out_if.source o_out,
    ctpk_cfg_if.sink  i_cfg
);

    // Weight of the oldest residue in the window, and the bound on any window code.
    localparam logic [CODE_W-1:0] WIN_WEIGHT = CODE_W'(pow20(KMER_LEN - 1));
    localparam logic [CODE_W:0]   CODE_LIMIT = (CODE_W + 1)'(pow20(KMER_LEN));
    localparam logic [POSITION_WIDTH-1:0] POS_MAX  = '1;
    localparam logic [POSITION_WIDTH-1:0] POS_BACK = POSITION_WIDTH'(KMER_LEN - 1);

    logic [1:0]                r_frame_offset;
    logic                      r_protein_input;
    logic [CODE_W-1:0]         r_code, n_code;
    logic [POSITION_WIDTH-1:0] r_pos, n_pos;
    logic                      r_out_valid;
    logic [CODE_W-1:0]         r_out_code;
    logic [POSITION_WIDTH-1:0] r_out_start;

    logic                      w_adv;
    t_s1                       w_s1;
    logic                      w_event;
    logic                      w_res_ok;
    logic                      w_flush;
    logic                      w_emit;
    logic [POSITION_WIDTH-1:0] w_pos_cur;
    logic                      w_sat;
    logic [POSITION_WIDTH-1:0] w_kmer_start;
    logic [CODE_W+4:0]         w_drop;
    logic [CODE_W-1:0]         w_core;
    logic [CODE_W+4:0]         w_scaled;
    logic [KMER_LEN-1:0]       w_valid;
    t_cell_ctl                 w_ctl_entry;
    t_cell_ctl                 w_ctl_rest;
    t_cell_data                w_entry_in;
    t_cell_data                w_cell [KMER_LEN];

    // The pipeline moves whenever the output register is empty or is being drained.
    assign w_adv       = !r_out_valid || o_out.ready;
    assign i_in.ready  = w_adv;
    assign i_cfg.ready = 1'b1;

    // Register writes land directly; they must only arrive while the block is idle, which nothing here checks.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_offset  <= '0;
            r_protein_input <= 1'b0;
        end else if (i_cfg.valid && i_cfg.ready) begin
            case (i_cfg.index)
                REG_FRAME_OFFSET:  r_frame_offset  <= i_cfg.data;
                REG_PROTEIN_INPUT: r_protein_input <= i_cfg.data[0];
                default:           r_frame_offset  <= r_frame_offset;
            endcase
        end
    end

    // Stage 1: frame handling, codon assembly and the residue lookup.
    ctpk_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_adv           (w_adv),
        .i_valid         (i_in.valid),
        .i_symbol        (i_in.symbol),
        .i_seq_start     (i_in.seq_start),
        .i_frame_offset  (r_frame_offset),
        .i_protein_input (r_protein_input),
        .o_s1            (w_s1)
    );

    // Stage 2 acts on a beat that carries a residue, a sequence start, or both.
    assign w_event  = w_adv && w_s1.valid;
    assign w_res_ok = w_s1.has_res && (w_s1.res != NO_RESIDUE);
    // A sequence start or an invalid residue empties the window.
    assign w_flush  = w_s1.start || (w_s1.has_res && !w_res_ok);

    // The entry cell takes the new residue; a flush empties every other cell.
    assign w_ctl_entry = '{shift: w_event, flush: 1'b0};
    assign w_ctl_rest  = '{shift: w_event, flush: w_flush};
    assign w_entry_in  = '{valid: w_res_ok, res: w_res_ok ? w_s1.res : '0};

    // Row of cells: cell 0 holds the newest residue, the last cell the oldest.
    for (genvar g = 0; g < KMER_LEN; g++) begin : g_cell
        if (g == 0) begin : g_entry
            ctpk_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_ctl   (w_ctl_entry),
                .i_prev  (w_entry_in),
                .o_cell  (w_cell[g])
            );
        end else begin : g_body
            ctpk_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_ctl   (w_ctl_rest),
                .i_prev  (w_cell[g-1]),
                .o_cell  (w_cell[g])
            );
        end
        assign w_valid[g] = w_cell[g].valid;
    end

    // The window is full after this residue when every cell that shifts on is valid.
    assign w_emit = w_res_ok && !w_flush && (&w_valid[KMER_LEN-2:0]);

    // Rolling code: drop the oldest residue's weight, scale by 20, add the new residue.
    // Empty cells hold zero, so the code always matches the cell contents.
    assign w_drop   = (CODE_W + 5)'(w_cell[KMER_LEN-1].res) * (CODE_W + 5)'(WIN_WEIGHT);
    assign w_core   = w_flush ? '0 : (r_code - w_drop[CODE_W-1:0]);
    assign w_scaled = ({5'b0, w_core} << 4) + ({5'b0, w_core} << 2)
                    + (CODE_W + 5)'(w_s1.res);

    // Position of the current residue; it stops at all ones.
    assign w_pos_cur = w_s1.start ? '0 : r_pos;
    assign w_sat     = (w_pos_cur == POS_MAX);
    assign w_kmer_start = w_sat ? POS_MAX
                        : ((w_pos_cur < POS_BACK) ? '0 : (w_pos_cur - POS_BACK));

    always_comb begin
        n_code = r_code;
        n_pos  = r_pos;
        if (w_event) begin
            n_code = w_res_ok ? w_scaled[CODE_W-1:0] : '0;
            if (w_s1.has_res) begin
                n_pos = w_sat ? w_pos_cur : (w_pos_cur + POSITION_WIDTH'(1));
            end else begin
                n_pos = w_pos_cur;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_code      <= '0;
            r_pos       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_code <= n_code;
            r_pos  <= n_pos;
            if (w_adv) begin
                r_out_valid <= w_event && w_emit;
            end
        end
    end

    // Result payload needs no reset; it is qualified by the output valid bit.
    always_ff @(posedge i_clk) begin
        if (w_event && w_emit) begin
            r_out_code  <= n_code;
            r_out_start <= w_kmer_start;
        end
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.kmer_code  = r_out_code;
    assign o_out.kmer_start = r_out_start;

    // A result on the port is always a legal base-20 code of the window length.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> ({1'b0, o_out.kmer_code} < CODE_LIMIT))
        else $error("kmer code out of range");

    // A held result must stall the symbol input.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !o_out.ready) |-> !i_in.ready)
        else $error("input accepted while result is stalled");

    // An invalid residue leaves the whole window empty.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_event && w_s1.has_res && !w_res_ok) |=> (w_valid == '0) && (r_code == '0))
        else $error("window not cleared by invalid residue");

    // Within a sequence the position never moves backward.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_event && !w_s1.start) |=> (r_pos >= $past(r_pos)))
        else $error("residue position decreased");

endmodule

FILE: rtl/ctpk_front.sv
// Front end: frame skipping, codon assembly and residue lookup into stage 1.
module ctpk_front
    import ctpk_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_adv,
    input  logic             i_valid,
    input  logic [SYM_W-1:0] i_symbol,
    input  logic             i_seq_start,
    input  logic [1:0]       i_frame_offset,
    input  logic             i_protein_input,
    output t_s1              o_s1
);

    logic [1:0]        r_skip, n_skip;
    logic [1:0]        r_phase, n_phase;
    logic [BASE_W-1:0] r_held0, n_held0;
    logic [BASE_W-1:0] r_held1, n_held1;
    t_s1               r_s1, n_s1;
    logic              w_accept;
    logic [BASE_W-1:0] w_base;
    logic              w_has_res;
    logic [RES_W-1:0]  w_res;

    assign w_accept = i_valid && i_adv;
    assign w_base   = base_code(i_symbol);

    always_comb begin
        n_skip    = i_seq_start ? 2'd0 : r_skip;
        n_phase   = i_seq_start ? 2'd0 : r_phase;
        n_held0   = i_seq_start ? '0 : r_held0;
        n_held1   = i_seq_start ? '0 : r_held1;
        w_has_res = 1'b0;
        w_res     = NO_RESIDUE;
        if (i_protein_input) begin
            w_has_res = 1'b1;
            w_res     = letter_residue(i_symbol);
        end else if (n_skip < i_frame_offset) begin
            n_skip = n_skip + 2'd1;
        end else if (n_phase < 2'd2) begin
            if (n_phase[0]) begin
                n_held1 = w_base;
            end else begin
                n_held0 = w_base;
            end
            n_phase = n_phase + 2'd1;
        end else begin
            n_phase   = 2'd0;
            w_has_res = 1'b1;
            if (!n_held0[2] && !n_held1[2] && !w_base[2]) begin
                w_res = CODON_RES[{n_held0[1:0], n_held1[1:0], w_base[1:0]}];
            end
        end
        n_s1.valid   = w_accept && (w_has_res || i_seq_start);
        n_s1.start   = i_seq_start;
        n_s1.has_res = w_has_res;
        n_s1.res     = w_res;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_skip  <= '0;
            r_phase <= '0;
            r_held0 <= '0;
            r_held1 <= '0;
            r_s1    <= '0;
        end else begin
            if (w_accept) begin
                r_skip  <= n_skip;
                r_phase <= n_phase;
                r_held0 <= n_held0;
                r_held1 <= n_held1;
            end
            if (i_adv) begin
                r_s1 <= n_s1;
            end
        end
    end

    assign o_s1 = r_s1;

endmodule

FILE: rtl/ctpk_cell.sv
// One window cell: holds a residue and its valid bit, shifts toward the oldest end.
module ctpk_cell
    import ctpk_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cell_ctl  i_ctl,
    input  t_cell_data i_prev,
    output t_cell_data o_cell
);

    t_cell_data r_cell, n_cell;

    always_comb begin
        n_cell = r_cell;
        if (i_ctl.shift) begin
            if (i_ctl.flush || !i_prev.valid) begin
                n_cell = '0;
            end else begin
                n_cell = i_prev;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cell <= '0;
        end else begin
            r_cell <= n_cell;
        end
    end

    assign o_cell = r_cell;

endmodule
